// ===== rtl/apss_pkg.sv =====
// ----------------------------------------------------------------------------
// apss_pkg
// Types, constants, pose tables and microcode for the arm pose slew sequencer.
// ----------------------------------------------------------------------------
package apss_pkg;

   typedef struct packed {
      logic [1:0]         operation;
      logic [2:0]         joint_index;
      logic signed [15:0] sensor_angle;
   } apss_req_type;

   typedef struct packed {
      logic [2:0]         joint_number;
      logic signed [15:0] command_angle;
      logic [12:0]        stiffness;
      logic               motion_done;
      logic               last;
   } apss_rsp_type;

   // operation codes
   localparam logic [1:0] OP_LOWER    = 2'd0;
   localparam logic [1:0] OP_TUCK     = 2'd1;
   localparam logic [1:0] OP_HOLD     = 2'd2;
   localparam logic [1:0] OP_RESERVED = 2'd3;

   // configuration register indexes
   localparam logic CSR_MAX_STEP  = 1'b0;
   localparam logic CSR_ARM_STIFF = 1'b1;

   localparam logic [12:0] MAX_STEP_RST = 13'd36;
   localparam logic [12:0] STIFF_ONE    = 13'd4096;
   localparam logic [12:0] HOLD_STIFF   = 13'd2867;
   localparam logic [16:0] GATE_TOL     = 17'd81;

   localparam logic signed [15:0] DEG10  = 16'sd715;
   localparam logic signed [15:0] DEG25  = 16'sd1787;
   localparam logic signed [15:0] DEG60  = 16'sd4289;
   localparam logic signed [15:0] DEG90  = 16'sd6434;
   localparam logic signed [15:0] DEG119 = 16'sd8507;

   // microcode
   localparam int PC_W = 5;

   typedef enum logic [1:0] {
      UOP_GATE,
      UOP_DEV,
      UOP_EMIT,
      UOP_HOLD
   } uop_type;

   typedef enum logic [1:0] {
      JMP_NONE,
      JMP_FAIL,
      JMP_ALWAYS
   } jmp_type;

   typedef struct packed {
      uop_type         uop;
      logic [2:0]      jnt;
      jmp_type         jmp;
      logic [PC_W-1:0] dest;
      logic            eop;
   } ctrl_word_type;

   localparam logic [PC_W-1:0] PC_BACK = 5'd0;
   localparam logic [PC_W-1:0] PC_DEV  = 5'd4;
   localparam logic [PC_W-1:0] PC_EMIT = 5'd12;
   localparam logic [PC_W-1:0] PC_DOWN = 5'd20;
   localparam logic [PC_W-1:0] PC_HOLD = 5'd22;
   localparam logic [PC_W-1:0] PC_LAST = 5'd22;
   localparam logic [PC_W-1:0] PASS_LEN = 5'd7;

   function automatic ctrl_word_type mk_cw(input uop_type u, input logic [2:0] j,
                                           input jmp_type m, input logic [PC_W-1:0] d,
                                           input logic e);
      ctrl_word_type w;
      w.uop  = u;
      w.jnt  = j;
      w.jmp  = m;
      w.dest = d;
      w.eop  = e;
      return w;
   endfunction

   // Program store: back gates, deviation pass, emit pass, down gates, hold.
   function automatic ctrl_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ctrl_word_type w;
      case (pc) inside
         PC_BACK:                    w = mk_cw(UOP_GATE, 3'd0, JMP_FAIL, PC_DEV, 1'b0);
         PC_BACK + 5'd1:             w = mk_cw(UOP_GATE, 3'd4, JMP_FAIL, PC_DEV, 1'b0);
         PC_BACK + 5'd2:             w = mk_cw(UOP_GATE, 3'd2, JMP_FAIL, PC_DEV, 1'b0);
         PC_BACK + 5'd3:             w = mk_cw(UOP_GATE, 3'd6, JMP_FAIL, PC_DEV, 1'b0);
         [PC_DEV:PC_DEV + PASS_LEN]: w = mk_cw(UOP_DEV, 3'(pc - PC_DEV), JMP_NONE,
                                               PC_DEV, 1'b0);
         [PC_EMIT:PC_EMIT + PASS_LEN]:
                                     w = mk_cw(UOP_EMIT, 3'(pc - PC_EMIT), JMP_NONE,
                                               PC_EMIT, pc == PC_EMIT + PASS_LEN);
         PC_DOWN:                    w = mk_cw(UOP_GATE, 3'd3, JMP_FAIL, PC_DEV, 1'b0);
         PC_DOWN + 5'd1:             w = mk_cw(UOP_GATE, 3'd7, JMP_ALWAYS, PC_DEV, 1'b0);
         PC_HOLD:                    w = mk_cw(UOP_HOLD, 3'd0, JMP_NONE, PC_HOLD, 1'b1);
         default:                    w = mk_cw(UOP_DEV, 3'd0, JMP_NONE, PC_BACK, 1'b1);
      endcase
      return w;
   endfunction

   // Target angle of one joint for the chosen pose and phase.
   function automatic logic signed [15:0] pose_target(input logic back, input logic fin,
                                                      input logic [2:0] j);
      logic signed [15:0] t;
      if (!back) begin
         case (j)
            3'd0:    t = fin ? DEG90 : DEG119;
            3'd1:    t = DEG10;
            3'd2:    t = fin ? -DEG90 : DEG25;
            3'd4:    t = fin ? DEG90 : DEG119;
            3'd5:    t = -DEG10;
            3'd6:    t = fin ? DEG90 : -DEG25;
            default: t = '0;
         endcase
      end else begin
         case (j)
            3'd0:    t = DEG119;
            3'd1:    t = fin ? 16'sd0 : DEG10;
            3'd2:    t = DEG25;
            3'd3:    t = fin ? -DEG60 : 16'sd0;
            3'd4:    t = DEG119;
            3'd5:    t = fin ? 16'sd0 : -DEG10;
            3'd6:    t = -DEG25;
            default: t = fin ? DEG60 : 16'sd0;
         endcase
      end
      return t;
   endfunction

endpackage

// ===== rtl/arm_pose_slew_sequencer.sv =====
// ----------------------------------------------------------------------------
// arm_pose_slew_sequencer
// Slews eight arm joint angles toward a staged pose under a microcoded program.
// ----------------------------------------------------------------------------
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  apss_req_type
//   rsp      out        rsp_valid / rsp_stall  apss_rsp_type
//   csr      in         csr_wr_en              csr_index, csr_wr_data
//
// One microcode step per cycle; an item is taken while the sequencer is idle,
// then runs its program: lower 17 or 18 steps, tuck 17 to 20 (gate check stops
// at the first miss), hold 1. The reserved operation is taken and dropped
// without starting a program. Emit and hold steps wait while the output
// register is full and stalled. Reset is synchronous: all angles zero,
// max_step 36, arm_stiffness 4096, no transfer pending.
// ----------------------------------------------------------------------------
module arm_pose_slew_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  apss_pkg::apss_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output apss_pkg::apss_rsp_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_index,
   input  logic [12:0]           csr_wr_data
);
   import apss_pkg::*;

   logic                busy_ff, busy_in;
   logic [PC_W-1:0]     pc_ff, pc_in;
   logic                back_ff, back_in;
   logic                fin_ff, fin_in;
   logic [2:0]          joint_ff, joint_in;
   logic signed [15:0]  sensor_ff, sensor_in;
   logic [16:0]         maxdev_ff, maxdev_in;
   logic [12:0]         max_step_ff, max_step_in;
   logic [12:0]         arm_stiff_ff, arm_stiff_in;
   logic signed [15:0]  angle_ff [8];
   logic signed [15:0]  angle_in [8];
   logic                rsp_valid_ff, rsp_valid_in;
   apss_rsp_type        rsp_data_ff, rsp_data_in;

   ctrl_word_type       cw;
   logic signed [15:0]  old_angle;
   logic signed [15:0]  tgt_angle;
   logic signed [16:0]  diff;
   logic [16:0]         mag;
   logic                gate_fail;
   logic [14:0]         lim;
   logic signed [17:0]  lim_s;
   logic signed [17:0]  diff_s;
   logic signed [17:0]  step;
   logic signed [17:0]  sum;
   logic                done;
   logic [12:0]         stiff_sat;
   logic                out_step;
   logic                out_free;
   logic                exec;
   logic                accept;

   assign req_stall = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign accept    = req_valid && !busy_ff;

   // datapath for the current step
   always_comb begin
      cw        = ucode_rom(pc_ff);
      old_angle = angle_ff[cw.jnt];
      tgt_angle = pose_target(back_ff, fin_ff, cw.jnt);
      diff      = {tgt_angle[15], tgt_angle} - {old_angle[15], old_angle};
      mag       = diff[16] ? 17'(-diff) : 17'(diff);
      gate_fail = mag > GATE_TOL;
      // elbow yaw may move four times as far
      lim       = (cw.jnt[1:0] == 2'd2) ? {max_step_ff, 2'b00} : {2'b00, max_step_ff};
      lim_s     = {3'b000, lim};
      diff_s    = {diff[16], diff};
      if (diff_s > lim_s) begin
         step = lim_s;
      end else if (diff_s < -lim_s) begin
         step = -lim_s;
      end else begin
         step = diff_s;
      end
      sum       = {{2{old_angle[15]}}, old_angle} + step;
      done      = fin_ff && (maxdev_ff < {4'b0000, max_step_ff});
      stiff_sat = (arm_stiff_ff > STIFF_ONE) ? STIFF_ONE : arm_stiff_ff;
      out_step  = (cw.uop == UOP_EMIT) || (cw.uop == UOP_HOLD);
      out_free  = !rsp_valid_ff || !rsp_stall;
      exec      = busy_ff && (!out_step || out_free);
   end

   always_comb begin
      busy_in      = busy_ff;
      pc_in        = pc_ff;
      back_in      = back_ff;
      fin_in       = fin_ff;
      joint_in     = joint_ff;
      sensor_in    = sensor_ff;
      maxdev_in    = maxdev_ff;
      max_step_in  = max_step_ff;
      arm_stiff_in = arm_stiff_ff;
      angle_in     = angle_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_STEP:  max_step_in  = csr_wr_data;
            CSR_ARM_STIFF: arm_stiff_in = csr_wr_data;
            default:       max_step_in  = max_step_ff;
         endcase
      end

      if (accept) begin
         joint_in  = req_data.joint_index;
         sensor_in = req_data.sensor_angle;
         back_in   = req_data.operation == OP_TUCK;
         fin_in    = 1'b1;
         maxdev_in = '0;
         case (req_data.operation)
            OP_LOWER: begin
               busy_in = 1'b1;
               pc_in   = PC_DOWN;
            end
            OP_TUCK: begin
               busy_in = 1'b1;
               pc_in   = PC_BACK;
            end
            OP_HOLD: begin
               busy_in = 1'b1;
               pc_in   = PC_HOLD;
            end
            default: begin
               // drop the reserved code
               busy_in = 1'b0;
            end
         endcase
      end else if (exec) begin
         case (cw.uop)
            UOP_GATE: begin
               if (gate_fail) begin
                  fin_in = 1'b0;
               end
            end
            UOP_DEV: begin
               if (mag > maxdev_ff) begin
                  maxdev_in = mag;
               end
            end
            UOP_EMIT: begin
               angle_in[cw.jnt]          = sum[15:0];
               rsp_valid_in              = 1'b1;
               rsp_data_in.joint_number  = cw.jnt;
               rsp_data_in.command_angle = sum[15:0];
               rsp_data_in.stiffness     = stiff_sat;
               rsp_data_in.motion_done   = done;
               rsp_data_in.last          = cw.eop;
            end
            default: begin
               angle_in[joint_ff]        = sensor_ff;
               rsp_valid_in              = 1'b1;
               rsp_data_in.joint_number  = joint_ff;
               rsp_data_in.command_angle = sensor_ff;
               rsp_data_in.stiffness     = HOLD_STIFF;
               rsp_data_in.motion_done   = 1'b0;
               rsp_data_in.last          = 1'b1;
            end
         endcase
         case (cw.jmp)
            JMP_ALWAYS: pc_in = cw.dest;
            JMP_FAIL:   pc_in = gate_fail ? cw.dest : pc_ff + 5'd1;
            default:    pc_in = pc_ff + 5'd1;
         endcase
         if (cw.eop) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PC_BACK;
         max_step_ff  <= MAX_STEP_RST;
         arm_stiff_ff <= STIFF_ONE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            angle_ff[i] <= '0;
         end
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         max_step_ff  <= max_step_in;
         arm_stiff_ff <= arm_stiff_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
      end
   end

   always_ff @(posedge clock) begin
      back_ff     <= back_in;
      fin_ff      <= fin_in;
      joint_ff    <= joint_in;
      sensor_ff   <= sensor_in;
      maxdev_ff   <= maxdev_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pc_ff <= PC_LAST)
      else $error("microcode counter left the program store");

   a_prog_end: assert property (@(posedge clock) disable iff (reset)
      (exec && cw.eop) |=> !busy_ff)
      else $error("sequencer still busy after end of program");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.operation != OP_RESERVED) |=> busy_ff)
      else $error("accepted item did not start a program");
`endif

endmodule
